FILE: rtl/psat_pkg.sv
// Shared types and constants of the probe source aging table.
// Used by probe_source_aging_table_core; depends on nothing else.
`default_nettype none

package psat_pkg;

	localparam int ADDR_W   = 48;
	localparam int TIME_W   = 32;
	localparam int EXPIRY_W = TIME_W + 1;
	localparam int LIFE_W   = 17;
	localparam int FC_W     = 8;
	localparam int COUNT_W  = 7;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_W  = 88;
	localparam int OUT_W = 24;

	localparam logic [FC_W-1:0]   PROBE_REQUEST_CODE = 8'h40;
	localparam logic [LIFE_W-1:0] LIFETIME_RESET     = 17'd1800;

	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		logic                valid;
		logic [EXPIRY_W-1:0] expiry;
		logic [ADDR_W-1:0]   address;
	} entry_t;

	typedef struct packed {
		count_t node_count;
		count_t retired_count;
		logic   dropped_full;
		logic   was_duplicate;
		logic   inserted_new;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SWEEP  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/probe_source_aging_table_core.sv
// Top level of the probe source aging table: entry memory, sweep sequencer and result register.
// Depends on psat_pkg.
`default_nettype none

// The block keeps up to TABLE_DEPTH transmitter addresses, each with an expiry time, in
// one synchronous memory. Every input transaction is one captured frame. A frame whose
// control byte is 0x40 (probe request) inserts its address into the lowest free entry with
// expiry now plus the configured lifetime, unless the address is already present (its
// expiry is then left alone) or the table is full (the address is dropped and flagged).
// Every frame then retires all entries whose expiry lies below its time. One result
// transaction follows each input transaction. For each accepted frame the memory's single
// read port is swept over every entry once, with lookup, free-slot search and retirement
// done on each word as it comes out, followed by a finishing state that writes the new
// entry and loads the result register once the output register is free. No new frame is
// accepted before that, but a finished result may wait in the output register while the
// next frame is accepted. After reset a clearing pass marks every entry free; no frame
// is accepted during it, while lifetime writes on the configuration port are taken as ever.
module probe_source_aging_table_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Input frames. s_tdata from bit 0: frame_control_byte[7:0], source_address[47:0],
	// now_seconds[31:0].
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [psat_pkg::IN_W-1:0]   s_tdata,
	// Results. m_tdata from bit 0: inserted_new, was_duplicate, dropped_full,
	// retired_count[6:0], node_count[6:0], zero padding.
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [psat_pkg::OUT_W-1:0]       m_tdata,
	// Lifetime register write channel.
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [psat_pkg::LIFE_W-1:0] cfg_data
);
	import psat_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	// Entry memory: one write port, one read port with registered data.
	entry_t entry_mem_q [TABLE_DEPTH];

	state_t              state_q;
	logic [LIFE_W-1:0]   lifetime_q;

	// Latched frame.
	logic                probe_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [TIME_W-1:0]   now_q;

	// Sweep control and the read stage.
	logic [IDX_W-1:0]    rd_idx_q;
	logic                issue_done_q;
	logic                valid_s1;
	logic [IDX_W-1:0]    idx_s1;
	entry_t              rd_s1;

	// Findings of the sweep.
	logic                found_q;
	logic                have_free_q;
	logic [IDX_W-1:0]    free_idx_q;
	count_t              retired_q;
	count_t              nodes_q;

	// Output register.
	logic                m_tvalid_q;
	result_t             result_q;

	logic                s_accept;
	logic                rd_en;
	logic                expired;
	logic                out_free;
	logic                do_insert;
	logic                finish_go;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	entry_t              wr_data;
	result_t             result_d;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = OUT_W'(result_q);

	assign rd_en    = (state_q == ST_SWEEP) && !issue_done_q;
	assign expired  = rd_s1.valid && (rd_s1.expiry < {1'b0, now_q});
	assign out_free = !m_tvalid_q || m_tready;

	assign finish_go = (state_q == ST_FINISH) && out_free;
	assign do_insert = finish_go && probe_q && !found_q && have_free_q;

	always_comb begin
		result_d.inserted_new  = probe_q && !found_q && have_free_q;
		result_d.was_duplicate = probe_q && found_q;
		result_d.dropped_full  = probe_q && !found_q && !have_free_q;
		result_d.retired_count = retired_q;
		result_d.node_count    = nodes_q + COUNT_W'(result_d.inserted_new);
	end

	// Write port: the clearing pass, retirement during the sweep and the final insertion
	// each own it in a state of their own.
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = rd_idx_q;
		wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_SWEEP: begin
				wr_en         = valid_s1 && expired;
				wr_idx        = idx_s1;
				wr_data       = rd_s1;
				wr_data.valid = 1'b0;
			end
			ST_FINISH: begin
				wr_en           = do_insert;
				wr_idx          = free_idx_q;
				wr_data.valid   = 1'b1;
				wr_data.expiry  = {1'b0, now_q} + EXPIRY_W'(lifetime_q);
				wr_data.address = addr_q;
			end
			ST_IDLE: begin
				wr_en = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1  <= entry_mem_q[rd_idx_q];
			idx_s1 <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			lifetime_q <= cfg_data;
		end
	end

	// Frame latch; payload only.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			probe_q <= (s_tdata[FC_W-1:0] == PROBE_REQUEST_CODE);
			addr_q  <= s_tdata[FC_W +: ADDR_W];
			now_q   <= s_tdata[FC_W+ADDR_W +: TIME_W];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			rd_idx_q     <= '0;
			issue_done_q <= 1'b0;
			valid_s1     <= 1'b0;
			found_q      <= 1'b0;
			have_free_q  <= 1'b0;
			free_idx_q   <= '0;
			retired_q    <= '0;
			nodes_q      <= '0;
		end else begin
			valid_s1 <= rd_en;
			unique case (state_q)
				ST_CLEAR: begin
					if (rd_idx_q == LAST_IDX) begin
						rd_idx_q <= '0;
						state_q  <= ST_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						rd_idx_q     <= '0;
						issue_done_q <= 1'b0;
						found_q      <= 1'b0;
						have_free_q  <= 1'b0;
						retired_q    <= '0;
						nodes_q      <= '0;
						state_q      <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
						if (rd_idx_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end
					end
					if (valid_s1) begin
						// Lookup and free-slot search see the table as it stood before
						// this frame's retirement.
						if (rd_s1.valid) begin
							if (rd_s1.address == addr_q) begin
								found_q <= 1'b1;
							end
							if (expired) begin
								retired_q <= retired_q + COUNT_W'(1);
							end else begin
								nodes_q <= nodes_q + COUNT_W'(1);
							end
						end else if (!have_free_q) begin
							have_free_q <= 1'b1;
							free_idx_q  <= idx_s1;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			result_q <= result_d;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("frame accepted during the clearing pass");

	a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q == ST_SWEEP) && !issue_done_q)
		else $error("accepted frame did not start a sweep");

	a_read_stage_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SWEEP))
		else $error("memory read data outside a sweep");

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go |-> $onehot0({result_d.inserted_new, result_d.was_duplicate,
			result_d.dropped_full}))
		else $error("more than one outcome flag in a result");

	a_insert_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> m_tvalid_q && (state_q == ST_IDLE))
		else $error("insertion without a result");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_probe_source_aging_table_core.sv
// Self-checking testbench for probe_source_aging_table_core: directed and random frames
// checked against a behavioral model of the address aging table. Depends on psat_pkg.
module tb_probe_source_aging_table_core;
	import psat_pkg::*;

	localparam int TABLE_DEPTH = 64;
	// EVENT_CYCLES is one event's span without stalls; HOLD_CYCLES is the longest receiver hold-off.
	localparam int EVENT_CYCLES = TABLE_DEPTH + 3;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 600;
	localparam int POOL_SIZE    = 80;
	localparam logic [LIFE_W-1:0] LIFETIME_MAX = '1;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LIFE_W-1:0] cfg_data;

	// Behavioral copy of the table and of the lifetime register.
	logic [ADDR_W-1:0]   model_addr [TABLE_DEPTH];
	logic [EXPIRY_W-1:0] model_expiry [TABLE_DEPTH];
	bit                  model_valid [TABLE_DEPTH];
	logic [LIFE_W-1:0]   model_lifetime;

	// Results predicted for accepted frames, oldest first.
	result_t pending_results[$];

	int  mismatch_count;
	int  quiet_cycles;
	int  hold_request;
	bit  sender_gaps_on;
	bit  receiver_stalls_on;

	probe_source_aging_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Idle stretches are mostly short, with an occasional long one.
	function automatic int idle_length();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 80);
	endfunction

	// Predicts the result of one frame and updates the model table. A probe request is
	// looked up and, when absent, stored in the lowest free entry. Insertion comes first,
	// so a full table drops the address even when entries expire in the same event.
	// Retirement then removes every entry whose expiry is strictly below the frame time.
	function automatic result_t age_table_event(input logic [FC_W-1:0] fc,
			input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now);
		result_t r;
		bit      found;
		bit      have_free;
		int      free_slot;
		int      retired;
		int      nodes;
		r         = '0;
		found     = 1'b0;
		have_free = 1'b0;
		free_slot = 0;
		retired   = 0;
		nodes     = 0;
		if (fc == PROBE_REQUEST_CODE) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (model_valid[i]) begin
					if (model_addr[i] == addr) begin
						found = 1'b1;
					end
				end else if (!have_free) begin
					have_free = 1'b1;
					free_slot = i;
				end
			end
			if (found) begin
				r.was_duplicate = 1'b1;
			end else if (have_free) begin
				model_addr[free_slot]   = addr;
				// The sum is carried in 33 bits, so it never wraps.
				model_expiry[free_slot] = {1'b0, now} + EXPIRY_W'(model_lifetime);
				model_valid[free_slot]  = 1'b1;
				r.inserted_new          = 1'b1;
			end else begin
				r.dropped_full = 1'b1;
			end
		end
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (model_valid[i]) begin
				if (model_expiry[i] < {1'b0, now}) begin
					model_valid[i] = 1'b0;
					retired++;
				end else begin
					nodes++;
				end
			end
		end
		r.retired_count = count_t'(retired);
		r.node_count    = count_t'(nodes);
		return r;
	endfunction

	function automatic void note_mismatch(input string what, input result_t want,
			input result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("MISMATCH %s: expected ins=%0d dup=%0d drop=%0d retired=%0d nodes=%0d,",
				what, want.inserted_new, want.was_duplicate, want.dropped_full,
				want.retired_count, want.node_count);
			$display("  actual ins=%0d dup=%0d drop=%0d retired=%0d nodes=%0d at %0t",
				got.inserted_new, got.was_duplicate, got.dropped_full,
				got.retired_count, got.node_count, $realtime);
		end
	endfunction

	// Offers one frame, waits for its transaction, records the predicted result and then
	// possibly idles. With no idle the valid stays high into the next call.
	task automatic send_frame(input logic [FC_W-1:0] fc, input logic [ADDR_W-1:0] addr,
			input logic [TIME_W-1:0] now);
		int gap;
		s_tdata  <= {now, addr, fc};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_results.insert(pending_results.size(), age_table_event(fc, addr, now));
		if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
			gap = idle_length();
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering frames and waits until every predicted result has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the lifetime register; only called while the block is idle.
	task automatic set_lifetime(input logic [LIFE_W-1:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		model_lifetime = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// The reset lifetime of 1800 s: an entry survives at exactly its expiry time and
	// leaves one second later.
	task automatic test_reset_lifetime();
		send_frame(PROBE_REQUEST_CODE, 48'h0200_0000_0001, 32'd1000);
		send_frame(8'h00, 48'h0200_0000_0001, 32'd2800);
		send_frame(8'h00, 48'h0200_0000_0001, 32'd2801);
		drain_results();
	endtask

	// Extreme addresses, times and control bytes at the largest lifetime. The frame at the
	// top of the time range gets an expiry above 32 bits, and later frames go back in time.
	task automatic test_field_extremes();
		set_lifetime(LIFETIME_MAX);
		send_frame(PROBE_REQUEST_CODE, 48'h0, 32'h0);
		send_frame(PROBE_REQUEST_CODE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_frame(8'hFF, 48'hFFFF_FFFF_FFFF, 32'h0);
		send_frame(PROBE_REQUEST_CODE, 48'hFFFF_FFFF_FFFF, 32'h0);
		send_frame(8'h41, 48'h0, 32'h1);
		send_frame(8'hC0, 48'hAAAA_5555_AAAA, 32'h5555_AAAA);
		send_frame(8'h00, 48'h5555_AAAA_5555, 32'hAAAA_5555);
		send_frame(8'hBF, 48'h0000_0000_0040, 32'h8000_0000);
		drain_results();
	endtask

	// With a zero lifetime the new entry survives its own event and any event at the
	// same time, then retires at the first later time.
	task automatic test_zero_lifetime();
		set_lifetime('0);
		send_frame(PROBE_REQUEST_CODE, 48'h1234_5678_9ABC, 32'd5000);
		send_frame(PROBE_REQUEST_CODE, 48'h1234_5678_9ABC, 32'd5000);
		send_frame(8'h00, 48'h1234_5678_9ABC, 32'd5000);
		send_frame(8'h00, 48'h1234_5678_9ABC, 32'd5001);
		send_frame(PROBE_REQUEST_CODE, 48'h1234_5678_9ABC, 32'd5001);
		send_frame(8'h80, 48'h0, 32'd5002);
		drain_results();
	endtask

	// Fills the table while the receiver holds off, so the block backs up and stalls its
	// input. A full table then drops a new address in an event that retires everything
	// that can expire.
	task automatic test_full_table();
		logic [TIME_W-1:0] t0;
		t0 = 32'hF000_0000;
		set_lifetime(17'd1000);
		// Clear out whatever earlier tests left that can still expire.
		send_frame(8'h00, 48'h0, t0);
		drain_results();
		sender_gaps_on = 1'b0;
		hold_request   = HOLD_CYCLES;
		for (int k = 0; k < TABLE_DEPTH + 6; k++) begin
			send_frame(PROBE_REQUEST_CODE, {32'hC0DE_0000, 16'(k)}, t0);
		end
		send_frame(PROBE_REQUEST_CODE, 48'h0BAD_0000_0001, t0 + 32'd2000);
		send_frame(PROBE_REQUEST_CODE, 48'h0BAD_0000_0002, t0 + 32'd2000);
		sender_gaps_on = 1'b1;
		drain_results();
	endtask

	// Random traffic in phases with different lifetimes. Most frames are probe requests
	// from a small address pool with a slowly advancing clock, so the table fills, ages
	// and refills; the rest are foreign control bytes, random addresses and time jumps.
	task automatic test_random_traffic(input int total_items);
		logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
		logic [TIME_W-1:0] cur_time;
		logic [TIME_W-1:0] now;
		logic [FC_W-1:0]   fc;
		logic [ADDR_W-1:0] addr;
		logic [LIFE_W-1:0] lifetime;
		int                per_phase;
		int                step_max;
		int                kind;
		per_phase = total_items / 10;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase % 5)
				0: lifetime = 17'd1800;
				1: lifetime = LIFETIME_MAX;
				2: lifetime = '0;
				3: lifetime = 17'($urandom_range(1, 300));
				default: lifetime = 17'($urandom_range(0, 131071));
			endcase
			if (phase == 8) begin
				lifetime = 17'd86400;
			end
			set_lifetime(lifetime);
			// A few phases run with no idling on either side.
			sender_gaps_on     = (phase != 2 && phase != 7);
			receiver_stalls_on = (phase != 2 && phase != 7);
			for (int k = 0; k < POOL_SIZE; k++) begin
				addr_pool[k] = {16'($urandom), $urandom};
			end
			cur_time = $urandom_range(0, 32'h7FFF_FFFF);
			step_max = int'(lifetime) / 128 + 2;
			for (int n = 0; n < per_phase; n++) begin
				kind = $urandom_range(0, 9);
				fc   = PROBE_REQUEST_CODE;
				addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
				if (kind < 8) begin
					cur_time = cur_time + 32'($urandom_range(0, step_max));
					now      = cur_time;
				end else if (kind == 8) begin
					fc   = 8'($urandom_range(0, 255));
					addr = {16'($urandom), $urandom};
					now  = cur_time;
				end else begin
					if ($urandom_range(0, 1) == 0) begin
						fc = 8'($urandom_range(0, 255));
					end
					if ($urandom_range(0, 1) == 0) begin
						now = $urandom;
					end else begin
						now = cur_time - 32'($urandom_range(0, step_max * 4));
					end
				end
				send_frame(fc, addr, now);
			end
			drain_results();
		end
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;
	endtask

	// Main sequence: reset once, run each test, then wait out the pipeline and report.
	initial begin
		arst_n             = 1'b0;
		s_tvalid           = 1'b0;
		s_tdata            = '0;
		m_tready           = 1'b0;
		cfg_valid          = 1'b0;
		cfg_data           = '0;
		mismatch_count     = 0;
		hold_request       = 0;
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;
		model_lifetime     = LIFETIME_RESET;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			model_valid[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_lifetime();
		test_field_extremes();
		test_zero_lifetime();
		test_full_table();
		test_random_traffic(1400);

		drain_results();
		repeat (EVENT_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Result side: mostly ready, with random stalls unless disabled, and a long hold-off
	// whenever a test asks for one. The hold-off length is counted here.
	initial begin : result_receiver
		int hold_len;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_len     = hold_request;
				hold_request = 0;
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				m_tready <= 1'b1;
			end else if (receiver_stalls_on && $urandom_range(0, 3) == 0) begin
				hold_len = idle_length();
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every result transaction is compared field by field with the oldest prediction.
	always @(posedge clk) begin : result_checker
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(result_t)-1:0];
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.inserted_new !== want.inserted_new
						|| got.was_duplicate !== want.was_duplicate
						|| got.dropped_full !== want.dropped_full
						|| got.retired_count !== want.retired_count
						|| got.node_count !== want.node_count) begin
					note_mismatch("result fields", want, got);
				end
			end
		end
	end

	// Watchdog: a long run of cycles without any transaction on any channel ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
